### rtl/patt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// patt_pkg: shared codes and helpers for the periodic alarm timer table
// Function, mode and result kind codes, calendar table, saturation helper.
// ----------------------------------------------------------------------------
package patt_pkg;

  localparam logic [1:0] FUNC_ARM    = 2'd0;
  localparam logic [1:0] FUNC_CANCEL = 2'd1;
  localparam logic [1:0] FUNC_TICK   = 2'd2;

  localparam logic [2:0] MODE_ONESHOT  = 3'd0;
  localparam logic [2:0] MODE_INTERVAL = 3'd1;
  localparam logic [2:0] MODE_HOURLY   = 3'd2;
  localparam logic [2:0] MODE_DAILY    = 3'd3;
  localparam logic [2:0] MODE_WEEKLY   = 3'd4;
  localparam logic [2:0] MODE_MONTHLY  = 3'd5;

  localparam logic [2:0] KIND_ARMED     = 3'd0;
  localparam logic [2:0] KIND_FULL      = 3'd1;
  localparam logic [2:0] KIND_CANCELLED = 3'd2;
  localparam logic [2:0] KIND_FIRED     = 3'd3;
  localparam logic [2:0] KIND_TICK_DONE = 3'd4;

  localparam logic [39:0] MAX40 = 40'hFF_FFFF_FFFF;
  localparam logic [22:0] SEC_PER_DAY = 23'd86400;

  localparam logic [4:0] DAYS_IN_MONTH [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // alarm period in seconds for hourly, daily and weekly modes
  function automatic logic [19:0] alarm_period(input logic [2:0] m);
    logic [19:0] p;
    unique case (m)
      MODE_HOURLY: p = 20'd3600;
      MODE_DAILY:  p = 20'd86400;
      default:     p = 20'd604800;
    endcase
    return p;
  endfunction

  // floor(2^40 / period), for the quotient estimate of the alarm alignment
  function automatic logic [28:0] alarm_recip(input logic [2:0] m);
    logic [28:0] r;
    unique case (m)
      MODE_HOURLY: r = 29'd305419896;
      MODE_DAILY:  r = 29'd12725829;
      default:     r = 29'd1817975;
    endcase
    return r;
  endfunction

  // saturate a signed value to 0 .. 2^40-1
  function automatic logic [39:0] sat40(input logic signed [43:0] v);
    logic [39:0] r;
    if (v < 44'sd0) r = 40'd0;
    else if (v > $signed({4'b0, MAX40})) r = MAX40;
    else r = v[39:0];
    return r;
  endfunction

endpackage

### rtl/periodic_alarm_timer_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_alarm_timer_table_core: table of software timers in local seconds
// Arm, cancel and tick handling over a slot table scanned by a sequencer.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; busy then stays high
// until the last result of that command has been put out. Every result shows
// for exactly one cycle with strobe high and cannot be held off, so the
// receiver must take it then; last marks the final result of a command. The
// slot table is walked one slot per cycle by a single index and compare
// unit. Arm scans for the lowest free slot, then computes the expiry; for
// hourly, daily and weekly alarms one shared multiplier first aligns the last
// tick time to the period: reciprocal quotient estimate, back-multiply,
// subtract, then two compare-and-subtract corrections. Cancel scans for the
// matching id. A tick with a new time makes one full scan per fired timer to
// pick the earliest due timer (ties to the lower id), plus a final scan that
// finds none; a tick at an unchanged time answers in the cycle after the
// transfer.
module periodic_alarm_timer_table_core #(
  parameter int TIMER_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func,
  input  logic [2:0]  mode,
  input  logic [30:0] amount,
  input  logic [31:0] target_id,
  input  logic [39:0] now_time,
  input  logic [4:0]  day_of_month,
  input  logic [4:0]  hour_of_day,
  input  logic [5:0]  minute_of_hour,
  input  logic [5:0]  second_of_minute,
  input  logic [3:0]  month_index,
  input  logic [11:0] full_year,
  output logic        strobe,
  output logic [2:0]  kind,
  output logic [31:0] result_id,
  output logic        found,
  output logic [4:0]  fired_count,
  output logic [39:0] due_time,
  output logic        last
);

  localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(TIMER_SLOTS - 1);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_ARM_SCAN  = 3'd1;
  localparam logic [2:0] S_ARM_REM   = 3'd2;
  localparam logic [2:0] S_ARM_CALC  = 3'd3;
  localparam logic [2:0] S_CAN_SCAN  = 3'd4;
  localparam logic [2:0] S_TICK_SCAN = 3'd5;
  localparam logic [2:0] S_TICK_FIRE = 3'd6;

  logic [2:0] state;

  // slot table
  logic [TIMER_SLOTS-1:0] slot_valid;
  logic [2:0]  slot_mode   [TIMER_SLOTS];
  logic [30:0] slot_amount [TIMER_SLOTS];
  logic [39:0] slot_expiry [TIMER_SLOTS];
  logic [31:0] slot_ident  [TIMER_SLOTS];
  logic [39:0] last_tick_time;
  logic [31:0] id_counter;

  // latched command fields
  logic [2:0]  mode_r;
  logic [30:0] amount_r;
  logic [31:0] tid_r;
  logic [39:0] now_r;
  logic [4:0]  day_r, hour_r;
  logic [5:0]  min_r, sec_r;
  logic [3:0]  month_r;
  logic [11:0] year_r;
  logic [12:0] yq25;        // year / 25

  // sequencer state
  logic [IW-1:0] idx;
  logic [2:0]    rem_cnt;
  logic [20:0]   rem;
  logic [28:0]   q_r;
  logic [39:0]   qp_r;
  logic [TIMER_SLOTS-1:0] done_mask;
  logic [4:0]    count;
  logic          best_found;
  logic [IW-1:0] best_idx;
  logic [39:0]   best_exp;
  logic [31:0]   best_id;
  logic [2:0]    best_mode;
  logic [30:0]   best_amt;

  assign busy = (state != S_IDLE);

  function automatic logic [4:0] DAYS_IN_MONTH_SEL(input logic [3:0] m);
    return patt_pkg::DAYS_IN_MONTH[m];
  endfunction

  // month length from the latched calendar, Gregorian leap rule
  logic [12:0] yr25;
  logic        leap;
  logic [3:0]  m_sat;
  logic [4:0]  mdays;
  logic [22:0] msecs;
  always_comb begin
    yr25  = {1'b0, year_r} - 13'(yq25 * 13'd25);
    leap  = (year_r[1:0] == 2'd0) && ((yr25 != 13'd0) || (year_r[3:0] == 4'd0));
    m_sat = (month_r > 4'd11) ? 4'd11 : month_r;
    mdays = DAYS_IN_MONTH_SEL(m_sat);
    if (m_sat == 4'd1 && leap) mdays = mdays + 5'd1;
    msecs = 23'(mdays) * patt_pkg::SEC_PER_DAY;
  end

  // calendar offset into the month
  logic signed [43:0] cal_off;
  always_comb begin
    cal_off = ($signed({39'b0, day_r}) - 44'sd1) * 44'sd86400
            + $signed({39'b0, hour_r}) * 44'sd3600
            + $signed({38'b0, min_r}) * 44'sd60
            + $signed({38'b0, sec_r});
  end

  // calendar terms are registered from the latched command fields, well before use
  logic [22:0]        msecs_r;
  logic signed [43:0] cal_off_r;
  always_ff @(posedge clk) begin
    msecs_r   <= msecs;
    cal_off_r <= cal_off;
  end

  // shared multiplier: quotient estimate first, then back-multiply by period
  logic [19:0] period;
  logic [31:0] mul_a;
  logic [28:0] mul_b;
  logic [60:0] mul_p;
  logic [39:0] rem_diff;
  always_comb begin
    period   = patt_pkg::alarm_period(mode_r);
    mul_a    = (rem_cnt == 3'd0) ? last_tick_time[39:8] : {3'b0, q_r};
    mul_b    = (rem_cnt == 3'd0) ? patt_pkg::alarm_recip(mode_r) : {9'b0, period};
    mul_p    = 61'(mul_a) * 61'(mul_b);
    rem_diff = last_tick_time - qp_r;   // below three periods
  end

  // first expiry of an armed timer
  logic signed [43:0] e0, e1, last_s;
  logic               is_alarm, is_month;
  logic [39:0]        arm_exp;
  always_comb begin
    last_s   = $signed({4'b0, last_tick_time});
    is_alarm = (mode_r == patt_pkg::MODE_HOURLY) || (mode_r == patt_pkg::MODE_DAILY) ||
               (mode_r == patt_pkg::MODE_WEEKLY);
    is_month = (mode_r == patt_pkg::MODE_MONTHLY);
    if (is_alarm)
      e0 = last_s - $signed({23'b0, rem}) + $signed({13'b0, amount_r});
    else if (is_month)
      e0 = last_s - cal_off_r + $signed({13'b0, amount_r});
    else
      e0 = last_s + $signed({13'b0, amount_r});
    e1 = e0;
    if (is_alarm && e0 <= last_s) e1 = e0 + $signed({24'b0, period});
    else if (is_month && e0 <= last_s) e1 = e0 + $signed({21'b0, msecs_r});
    arm_exp = patt_pkg::sat40(e1);
  end

  // tick scan candidate
  logic [39:0] cand_exp;
  logic [31:0] cand_id;
  logic        cand_take;
  always_comb begin
    cand_exp  = slot_expiry[idx];
    cand_id   = slot_ident[idx];
    cand_take = slot_valid[idx] && !done_mask[idx] && (cand_exp <= now_r) &&
                (!best_found || (cand_exp < best_exp) ||
                 ((cand_exp == best_exp) && (cand_id < best_id)));
  end

  // re-arm value of the fired timer
  logic [39:0] rearm_exp;
  always_comb begin
    unique case (best_mode)
      patt_pkg::MODE_INTERVAL:
        rearm_exp = patt_pkg::sat40($signed({4'b0, now_r}) + $signed({13'b0, best_amt}));
      patt_pkg::MODE_MONTHLY:
        rearm_exp = patt_pkg::sat40($signed({4'b0, best_exp}) + $signed({21'b0, msecs_r}));
      default:
        rearm_exp = patt_pkg::sat40($signed({4'b0, best_exp}) +
                                    $signed({24'b0, patt_pkg::alarm_period(best_mode)}));
    endcase
  end

  always_ff @(posedge clk) begin
    strobe <= 1'b0;
    if (rst) begin
      state          <= S_IDLE;
      slot_valid     <= '0;
      last_tick_time <= 40'd0;
      id_counter     <= 32'd0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            mode_r   <= mode;
            amount_r <= amount;
            tid_r    <= target_id;
            now_r    <= now_time;
            day_r    <= day_of_month;
            hour_r   <= hour_of_day;
            min_r    <= minute_of_hour;
            sec_r    <= second_of_minute;
            month_r  <= month_index;
            year_r   <= full_year;
            yq25     <= 13'((25'(full_year) * 25'd5243) >> 17);
            idx      <= '0;
            unique case (func)
              patt_pkg::FUNC_ARM:    state <= S_ARM_SCAN;
              patt_pkg::FUNC_CANCEL: state <= S_CAN_SCAN;
              patt_pkg::FUNC_TICK: begin
                if (now_time == last_tick_time) begin
                  strobe      <= 1'b1;
                  kind        <= patt_pkg::KIND_TICK_DONE;
                  result_id   <= 32'd0;
                  found       <= 1'b0;
                  fired_count <= 5'd0;
                  due_time    <= 40'd0;
                  last        <= 1'b1;
                end else begin
                  last_tick_time <= now_time;
                  done_mask      <= '0;
                  count          <= 5'd0;
                  best_found     <= 1'b0;
                  state          <= S_TICK_SCAN;
                end
              end
              default: ;  // unknown func: no results
            endcase
          end
        end

        S_ARM_SCAN: begin
          if (!slot_valid[idx]) begin
            rem_cnt <= 3'd0;
            state   <= is_alarm ? S_ARM_REM : S_ARM_CALC;
          end else if (idx == LAST_IDX) begin
            strobe      <= 1'b1;
            kind        <= patt_pkg::KIND_FULL;
            result_id   <= 32'd0;
            found       <= 1'b0;
            fired_count <= 5'd0;
            due_time    <= 40'd0;
            last        <= 1'b1;
            state       <= S_IDLE;
          end else begin
            idx <= idx + IW'(1);
          end
        end

        // last tick time modulo period: estimate, back-multiply, subtract, two corrections
        S_ARM_REM: begin
          rem_cnt <= rem_cnt + 3'd1;
          unique case (rem_cnt)
            3'd0: q_r  <= mul_p[60:32];
            3'd1: qp_r <= mul_p[39:0];
            3'd2: rem  <= rem_diff[20:0];
            default: begin
              if (rem >= {1'b0, period}) rem <= rem - {1'b0, period};
              if (rem_cnt == 3'd4) state <= S_ARM_CALC;
            end
          endcase
        end

        S_ARM_CALC: begin
          id_counter        <= id_counter + 32'd1;
          slot_valid[idx]   <= 1'b1;
          slot_mode[idx]    <= mode_r;
          slot_amount[idx]  <= amount_r;
          slot_expiry[idx]  <= arm_exp;
          slot_ident[idx]   <= id_counter + 32'd1;
          strobe            <= 1'b1;
          kind              <= patt_pkg::KIND_ARMED;
          result_id         <= id_counter + 32'd1;
          found             <= 1'b0;
          fired_count       <= 5'd0;
          due_time          <= arm_exp;
          last              <= 1'b1;
          state             <= S_IDLE;
        end

        S_CAN_SCAN: begin
          if ((slot_valid[idx] && slot_ident[idx] == tid_r) || idx == LAST_IDX) begin
            if (slot_valid[idx] && slot_ident[idx] == tid_r) slot_valid[idx] <= 1'b0;
            strobe      <= 1'b1;
            kind        <= patt_pkg::KIND_CANCELLED;
            result_id   <= tid_r;
            found       <= slot_valid[idx] && (slot_ident[idx] == tid_r);
            fired_count <= 5'd0;
            due_time    <= 40'd0;
            last        <= 1'b1;
            state       <= S_IDLE;
          end else begin
            idx <= idx + IW'(1);
          end
        end

        S_TICK_SCAN: begin
          if (cand_take) begin
            best_found <= 1'b1;
            best_idx   <= idx;
            best_exp   <= cand_exp;
            best_id    <= cand_id;
            best_mode  <= slot_mode[idx];
            best_amt   <= slot_amount[idx];
          end
          if (idx == LAST_IDX) state <= S_TICK_FIRE;
          else idx <= idx + IW'(1);
        end

        S_TICK_FIRE: begin
          strobe <= 1'b1;
          found  <= 1'b0;
          if (best_found) begin
            kind                <= patt_pkg::KIND_FIRED;
            result_id           <= best_id;
            fired_count         <= 5'd0;
            due_time            <= best_exp;
            last                <= 1'b0;
            count               <= count + 5'd1;
            done_mask[best_idx] <= 1'b1;
            unique case (best_mode)
              patt_pkg::MODE_INTERVAL, patt_pkg::MODE_HOURLY, patt_pkg::MODE_DAILY,
              patt_pkg::MODE_WEEKLY, patt_pkg::MODE_MONTHLY:
                slot_expiry[best_idx] <= rearm_exp;
              default: slot_valid[best_idx] <= 1'b0;  // one-shot and unknown modes
            endcase
            idx        <= '0;
            best_found <= 1'b0;
            state      <= S_TICK_SCAN;
          end else begin
            kind        <= patt_pkg::KIND_TICK_DONE;
            result_id   <= 32'd0;
            fired_count <= count;
            due_time    <= 40'd0;
            last        <= 1'b1;
            state       <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_tick_done_last: assert property (@(posedge clk) disable iff (rst)
    strobe && kind == patt_pkg::KIND_TICK_DONE |-> last)
    else $error("tick done without last");
  a_fired_not_last: assert property (@(posedge clk) disable iff (rst)
    strobe && kind == patt_pkg::KIND_FIRED |-> !last)
    else $error("fired result marked last");
  a_arm_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && func == patt_pkg::FUNC_ARM |=> busy)
    else $error("arm transfer did not raise busy");
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    strobe && (kind == patt_pkg::KIND_ARMED || kind == patt_pkg::KIND_FULL ||
               kind == patt_pkg::KIND_CANCELLED) |-> last && !busy)
    else $error("single result command not finished");
`endif

endmodule

### sim/periodic_alarm_timer_table_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_alarm_timer_table_core_tb: self-checking bench for the timer table
// Directed rows, then biased random commands. A behavioral copy of the table
// predicts untyped results; each is compared field by field as it comes out.
// ----------------------------------------------------------------------------
module periodic_alarm_timer_table_core_tb;

  localparam int          SLOTS       = 16;
  localparam logic [1:0]  FUNC_UNUSED = 2'd3;   // ignored by the block
  localparam logic [2:0]  MODE_SPARE6 = 3'd6;   // acts as one-shot
  localparam logic [2:0]  MODE_SPARE7 = 3'd7;
  localparam longint      TOP40       = 64'hFF_FFFF_FFFF;
  localparam int          RAND_CMDS   = 200;
  localparam int          STALL_LIMIT = 3000;

  typedef struct {
    logic [2:0]  kind;
    logic [31:0] id;
    logic        found;
    logic [4:0]  count;
    logic [39:0] due;
    logic        last;
  } outcome_t;

  // one command; "typed" rows carry a hand-written single result
  typedef struct {
    logic [1:0]  fn;
    logic [2:0]  md;
    logic [30:0] amt;
    logic [31:0] tid;
    logic [39:0] now;
    logic [4:0]  dom;
    logic [4:0]  hr;
    logic [5:0]  mn;
    logic [5:0]  sc;
    logic [3:0]  mon;
    logic [11:0] yr;
    bit          typed;
    outcome_t    want;
  } cmd_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  func = '0;
  logic [2:0]  mode = '0;
  logic [30:0] amount = '0;
  logic [31:0] target_id = '0;
  logic [39:0] now_time = '0;
  logic [4:0]  day_of_month = 5'd1;
  logic [4:0]  hour_of_day = '0;
  logic [5:0]  minute_of_hour = '0;
  logic [5:0]  second_of_minute = '0;
  logic [3:0]  month_index = '0;
  logic [11:0] full_year = 12'd2000;
  logic        strobe;
  logic [2:0]  kind;
  logic [31:0] result_id;
  logic        found;
  logic [4:0]  fired_count;
  logic [39:0] due_time;
  logic        last;

  periodic_alarm_timer_table_core #(.TIMER_SLOTS(SLOTS)) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .func(func), .mode(mode), .amount(amount), .target_id(target_id),
    .now_time(now_time), .day_of_month(day_of_month), .hour_of_day(hour_of_day),
    .minute_of_hour(minute_of_hour), .second_of_minute(second_of_minute),
    .month_index(month_index), .full_year(full_year),
    .strobe(strobe), .kind(kind), .result_id(result_id), .found(found),
    .fired_count(fired_count), .due_time(due_time), .last(last)
  );

  always #5 clk = ~clk;

  // ---- shadow of the timer table ----
  bit          tbl_live [SLOTS];
  logic [2:0]  tbl_mode [SLOTS];
  logic [30:0] tbl_amt  [SLOTS];
  longint      tbl_exp  [SLOTS];
  logic [31:0] tbl_id   [SLOTS];
  longint      tick_last;
  logic [31:0] ids_issued;

  outcome_t pending_q[$];   // results still owed by the block
  int       errors = 0;
  int       quiet_cycles = 0;

  function automatic longint clip40(longint v);
    if (v < 0) return 0;
    if (v > TOP40) return TOP40;
    return v;
  endfunction

  function automatic longint period_secs(logic [2:0] m);
    if (m == patt_pkg::MODE_HOURLY) return 3600;
    if (m == patt_pkg::MODE_DAILY) return 86400;
    return 604800;
  endfunction

  // month length in seconds, Gregorian leap rule; month index saturates at 11
  function automatic longint month_secs(logic [3:0] mon, logic [11:0] yr);
    int     mi;
    longint d;
    longint y;
    mi = (mon > 11) ? 11 : int'(mon);
    d  = patt_pkg::DAYS_IN_MONTH[mi];
    y  = longint'(yr);
    if (mi == 1 && y % 4 == 0 && (y % 100 != 0 || y % 400 == 0)) d++;
    return d * 86400;
  endfunction

  function automatic outcome_t mk(logic [2:0] k, logic [31:0] id, logic f,
                                  logic [4:0] c, logic [39:0] d);
    outcome_t o;
    o.kind = k; o.id = id; o.found = f; o.count = c; o.due = d; o.last = 1'b0;
    return o;
  endfunction

  // advance the shadow table by one command, return the results it owes
  function automatic void table_step(input cmd_t c, output outcome_t rs[$]);
    int     slot;
    int     pick;
    longint ex;
    longint p;
    longint ofs;
    bit     fired [SLOTS];
    int     nfire;
    rs = {};
    slot = -1;
    case (c.fn)
      patt_pkg::FUNC_ARM: begin
        for (int i = 0; i < SLOTS; i++)
          if (!tbl_live[i] && slot < 0) slot = i;
        if (slot < 0) begin
          rs.push_back(mk(patt_pkg::KIND_FULL, '0, 1'b0, '0, '0));
        end else begin
          if (c.md >= patt_pkg::MODE_HOURLY && c.md <= patt_pkg::MODE_WEEKLY) begin
            p  = period_secs(c.md);
            ex = (tick_last / p) * p + longint'(c.amt);
            if (ex <= tick_last) ex += p;
          end else if (c.md == patt_pkg::MODE_MONTHLY) begin
            // day 0 deliberately gives a negative day term
            ofs = (longint'(c.dom) - 1) * 86400 + longint'(c.hr) * 3600
                + longint'(c.mn) * 60 + longint'(c.sc);
            ex = tick_last - ofs + longint'(c.amt);
            if (ex <= tick_last) ex += month_secs(c.mon, c.yr);
          end else begin
            ex = tick_last + longint'(c.amt);
          end
          ex = clip40(ex);
          ids_issued++;
          tbl_live[slot] = 1'b1; tbl_mode[slot] = c.md; tbl_amt[slot] = c.amt;
          tbl_exp[slot] = ex; tbl_id[slot] = ids_issued;
          rs.push_back(mk(patt_pkg::KIND_ARMED, ids_issued, 1'b0, '0, ex[39:0]));
        end
      end
      patt_pkg::FUNC_CANCEL: begin
        for (int i = 0; i < SLOTS; i++)
          if (slot < 0 && tbl_live[i] && tbl_id[i] == c.tid) slot = i;
        if (slot >= 0) tbl_live[slot] = 1'b0;
        rs.push_back(mk(patt_pkg::KIND_CANCELLED, c.tid, slot >= 0, '0, '0));
      end
      patt_pkg::FUNC_TICK: begin
        nfire = 0;
        for (int i = 0; i < SLOTS; i++) fired[i] = 1'b0;
        if (longint'(c.now) != tick_last) begin
          tick_last = longint'(c.now);
          // each timer fires at most once; earliest first, ties to lower id
          forever begin
            pick = -1;
            for (int i = 0; i < SLOTS; i++) begin
              if (tbl_live[i] && !fired[i] && tbl_exp[i] <= tick_last) begin
                if (pick < 0 || tbl_exp[i] < tbl_exp[pick] ||
                    (tbl_exp[i] == tbl_exp[pick] && tbl_id[i] < tbl_id[pick]))
                  pick = i;
              end
            end
            if (pick < 0) break;
            fired[pick] = 1'b1;
            nfire++;
            rs.push_back(mk(patt_pkg::KIND_FIRED, tbl_id[pick], 1'b0, '0,
                            tbl_exp[pick][39:0]));
            case (tbl_mode[pick])
              patt_pkg::MODE_INTERVAL:
                tbl_exp[pick] = clip40(tick_last + longint'(tbl_amt[pick]));
              patt_pkg::MODE_HOURLY, patt_pkg::MODE_DAILY, patt_pkg::MODE_WEEKLY:
                tbl_exp[pick] = clip40(tbl_exp[pick] + period_secs(tbl_mode[pick]));
              patt_pkg::MODE_MONTHLY:
                tbl_exp[pick] = clip40(tbl_exp[pick] + month_secs(c.mon, c.yr));
              default: tbl_live[pick] = 1'b0;   // one-shot and spare modes
            endcase
          end
        end
        rs.push_back(mk(patt_pkg::KIND_TICK_DONE, '0, 1'b0, 5'(nfire), '0));
      end
      default: ;
    endcase
    if (rs.size() > 0) rs[rs.size() - 1].last = 1'b1;
  endfunction

  // ---- result checker: every strobe must match the oldest expectation ----
  always @(posedge clk) begin
    outcome_t w;
    if (!rst) begin
      if ((start && !busy) || strobe) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
    if (!rst && strobe) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result kind=%0d id=%0d", kind, result_id);
        errors++;
      end else begin
        w = pending_q.pop_front();
        if (kind !== w.kind) begin
          $error("kind: expected %0d, got %0d", w.kind, kind); errors++;
        end
        if (result_id !== w.id) begin
          $error("result_id: expected %0d, got %0d", w.id, result_id); errors++;
        end
        if (found !== w.found) begin
          $error("found: expected %0d, got %0d", w.found, found); errors++;
        end
        if (fired_count !== w.count) begin
          $error("fired_count: expected %0d, got %0d", w.count, fired_count); errors++;
        end
        if (due_time !== w.due) begin
          $error("due_time: expected %0d, got %0d", w.due, due_time); errors++;
        end
        if (last !== w.last) begin
          $error("last: expected %0d, got %0d", w.last, last); errors++;
        end
      end
    end
  end

  // ---- sender ----
  bit calm = 1'b0;   // no idling while set

  // present one command and hold it until the transfer happens
  task automatic issue(input cmd_t c);
    outcome_t rs[$];
    if (!calm && $urandom_range(99) < 32) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    func <= c.fn; mode <= c.md; amount <= c.amt; target_id <= c.tid;
    now_time <= c.now; day_of_month <= c.dom; hour_of_day <= c.hr;
    minute_of_hour <= c.mn; second_of_minute <= c.sc; month_index <= c.mon;
    full_year <= c.yr;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    table_step(c, rs);
    if (c.typed) begin
      c.want.last = 1'b1;
      pending_q.push_back(c.want);
    end else begin
      foreach (rs[i]) pending_q.push_back(rs[i]);
    end
  endtask

  function automatic cmd_t blank(logic [1:0] fn);
    cmd_t c;
    c.fn = fn; c.md = patt_pkg::MODE_ONESHOT; c.amt = '0; c.tid = '0; c.now = '0;
    c.dom = 5'd1; c.hr = '0; c.mn = '0; c.sc = '0; c.mon = '0; c.yr = 12'd2001;
    c.typed = 1'b0; c.want = mk('0, '0, 1'b0, '0, '0);
    return c;
  endfunction

  function automatic cmd_t arm(logic [2:0] md, logic [30:0] amt);
    cmd_t c;
    c = blank(patt_pkg::FUNC_ARM); c.md = md; c.amt = amt;
    return c;
  endfunction

  function automatic cmd_t tick(logic [39:0] now);
    cmd_t c;
    c = blank(patt_pkg::FUNC_TICK); c.now = now;
    return c;
  endfunction

  function automatic cmd_t cancel(logic [31:0] tid);
    cmd_t c;
    c = blank(patt_pkg::FUNC_CANCEL); c.tid = tid;
    return c;
  endfunction

  function automatic cmd_t typed(cmd_t c, outcome_t w);
    c.typed = 1'b1; c.want = w;
    return c;
  endfunction

  // mostly realistic random command, with a share of full-width noise
  function automatic cmd_t random_cmd();
    cmd_t   c;
    int     r;
    bit     wild;
    longint t;
    r = $urandom_range(99);
    wild = ($urandom_range(9) == 0);
    if (r < 45) begin
      c = blank(patt_pkg::FUNC_ARM);
      c.md  = wild ? 3'($urandom) : 3'($urandom_range(5));
      c.amt = wild ? 31'($urandom) : ($urandom_range(3) == 0 ?
              31'($urandom_range(700000)) : 31'($urandom_range(5000)));
      c.dom = wild ? 5'($urandom) : 5'($urandom_range(1, 31));
      c.hr  = wild ? 5'($urandom) : 5'($urandom_range(23));
      c.mn  = wild ? 6'($urandom) : 6'($urandom_range(59));
      c.sc  = wild ? 6'($urandom) : 6'($urandom_range(59));
    end else if (r < 65) begin
      c = blank(patt_pkg::FUNC_CANCEL);
      c.tid = wild ? $urandom : ids_issued - 32'($urandom_range(20));
    end else if (r < 98) begin
      c = blank(patt_pkg::FUNC_TICK);
      t = tick_last;
      case ($urandom_range(9))
        0:       c.now = 40'(t);                                  // unchanged time
        1:       c.now = 40'(t > 3000 ? t - $urandom_range(3000) : 0);  // goes back
        2:       c.now = {8'($urandom), $urandom};
        default: c.now = 40'(clip40(t + $urandom_range(1, 8000)));
      endcase
    end else begin
      c = blank(FUNC_UNUSED);
      c.amt = 31'($urandom); c.tid = $urandom;
    end
    c.mon = wild ? 4'($urandom) : 4'($urandom_range(11));
    c.yr  = wild ? 12'($urandom) : 12'($urandom_range(1970, 2399));
    return c;
  endfunction

  cmd_t plan[$];
  cmd_t c;

  initial begin
    for (int i = 0; i < SLOTS; i++) tbl_live[i] = 1'b0;
    tick_last = 0;
    ids_issued = '0;

    // directed rows
    plan.push_back(typed(tick(40'd0),
                         mk(patt_pkg::KIND_TICK_DONE, 32'd0, 1'b0, 5'd0, 40'd0)));
    plan.push_back(typed(arm(patt_pkg::MODE_ONESHOT, 31'd0),
                         mk(patt_pkg::KIND_ARMED, 32'd1, 1'b0, 5'd0, 40'd0)));
    plan.push_back(typed(cancel(32'd999),
                         mk(patt_pkg::KIND_CANCELLED, 32'd999, 1'b0, 5'd0, 40'd0)));
    plan.push_back(tick(40'd5));
    plan.push_back(typed(arm(patt_pkg::MODE_INTERVAL, 31'd10),
                         mk(patt_pkg::KIND_ARMED, 32'd2, 1'b0, 5'd0, 40'd15)));
    plan.push_back(arm(patt_pkg::MODE_HOURLY, 31'd0));
    plan.push_back(arm(patt_pkg::MODE_DAILY, 31'd100));
    plan.push_back(arm(patt_pkg::MODE_WEEKLY, 31'h7FFF_FFFF));
    c = arm(patt_pkg::MODE_MONTHLY, 31'd0);
    c.dom = 5'd31; c.hr = 5'd23; c.mn = 6'd59; c.sc = 6'd59; c.mon = 4'd1;
    c.yr = 12'd2000;
    plan.push_back(c);
    c = arm(patt_pkg::MODE_MONTHLY, 31'd5);   // day zero and month index past December
    c.dom = 5'd0; c.mon = 4'd15; c.yr = 12'd2100;
    plan.push_back(c);
    plan.push_back(arm(MODE_SPARE6, 31'd1));
    plan.push_back(arm(MODE_SPARE7, 31'd2));
    plan.push_back(typed(cancel(32'd3),
                         mk(patt_pkg::KIND_CANCELLED, 32'd3, 1'b1, 5'd0, 40'd0)));
    c = blank(FUNC_UNUSED); c.amt = 31'h7FFF_FFFF;
    plan.push_back(c);
    c = tick(40'd1_000_000); c.mon = 4'd1; c.yr = 12'd2024;
    plan.push_back(c);
    plan.push_back(typed(tick(40'd1_000_000),
                         mk(patt_pkg::KIND_TICK_DONE, 32'd0, 1'b0, 5'd0, 40'd0)));
    plan.push_back(tick(40'd10));        // time going back
    plan.push_back(tick(40'hFF_FFFF_FFFF));
    plan.push_back(arm(patt_pkg::MODE_INTERVAL, 31'h7FFF_FFFF));   // saturates at the top
    plan.push_back(tick(40'd0));

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) issue(plan[i]);

    for (int n = 0; n < RAND_CMDS; n++) begin
      calm = (n >= 100 && n < 150);
      // fill the table now and then so the full case is hit
      if (n % 60 == 30)
        for (int k = 0; k < SLOTS + 1; k++) issue(arm(3'($urandom_range(5)),
                                                  31'($urandom_range(4000))));
      if (n == 180) begin
        start <= 1'b0;
        wait (pending_q.size() == 0);
        @(posedge clk);
      end
      issue(random_cmd());
    end
    start <= 1'b0;

    wait (pending_q.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
